// ===== rtl/u8dec_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and byte-classing functions for the UTF-8 to UCS-2 decoder.
// No dependencies; imported by every module of the block but the checker.
package u8dec_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int MAX_UNITS = 3;
    localparam int CNT_W     = 2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // number of bytes held from an unfinished sequence
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } pend_t;

    // all code units caused by one input item, oldest in units[0]
    typedef struct packed {
        unit_t [MAX_UNITS-1:0] units;
        cnt_t                  cnt;
        logic                  last;
    } bundle_t;

    function automatic logic is_cont(input byte_t b);
        is_cont = (b[7:6] == 2'b10);
    endfunction

    function automatic logic is_lead(input byte_t b);
        is_lead = (b[7:6] == 2'b11);
    endfunction

    function automatic logic is_lead3(input byte_t b);
        is_lead3 = (b[7:5] == 3'b111);
    endfunction

    function automatic unit_t raw_unit(input byte_t b);
        raw_unit = {{(UNIT_W-BYTE_W){1'b0}}, b};
    endfunction

    function automatic unit_t unit2(input byte_t lead, input byte_t c1);
        unit2 = {5'b00000, lead[4:0], c1[5:0]};
    endfunction

    function automatic unit_t unit3(input byte_t lead, input byte_t c1, input byte_t c2);
        unit3 = {lead[3:0], c1[5:0], c2[5:0]};
    endfunction

endpackage

// ===== rtl/u8dec_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the pending sequence and builds a bundle for each byte that releases units.
// Depends on u8dec_pkg.
module u8dec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  u8dec_pkg::byte_t   s_tdata,
    input  logic               s_tlast,
    output logic               push_valid,
    input  logic               push_ready,
    output u8dec_pkg::bundle_t push_data
);
    import u8dec_pkg::*;

    pend_t pend_reg, pend_next, pend_keep;
    byte_t p0_reg, p0_next;
    byte_t p1_reg, p1_next;
    unit_t [MAX_UNITS-1:0] units;
    cnt_t  n;
    logic  fresh;
    logic  accept;

    assign s_tready = push_ready;
    assign accept   = s_tvalid && push_ready;

    always_comb
    begin
        units     = '0;
        n         = '0;
        fresh     = 1'b0;
        pend_keep = PEND_NONE;
        p0_next   = p0_reg;
        p1_next   = p1_reg;
        case (pend_reg)
            PEND_NONE:
            begin
                fresh = 1'b1;
            end
            PEND_ONE:
            begin
                if (is_cont(s_tdata))
                begin
                    if (is_lead3(p0_reg))
                    begin
                        p1_next   = s_tdata;
                        pend_keep = PEND_TWO;
                    end
                    else
                    begin
                        units[0] = unit2(p0_reg, s_tdata);
                        n        = 2'd1;
                    end
                end
                else
                begin
                    units[0] = raw_unit(p0_reg);
                    n        = 2'd1;
                    fresh    = 1'b1;
                end
            end
            PEND_TWO:
            begin
                if (is_cont(s_tdata))
                begin
                    units[0] = unit3(p0_reg, p1_reg, s_tdata);
                    n        = 2'd1;
                end
                else
                begin
                    units[0] = raw_unit(p0_reg);
                    units[1] = raw_unit(p1_reg);
                    n        = 2'd2;
                    fresh    = 1'b1;
                end
            end
            default:
            begin
                fresh = 1'b1;
            end
        endcase

        if (fresh)
        begin
            if (is_lead(s_tdata))
            begin
                p0_next   = s_tdata;
                pend_keep = PEND_ONE;
            end
            else
            begin
                units[n] = raw_unit(s_tdata);
                n        = 2'(n + 2'd1);
            end
        end

        // flush what is still held at the end of the string
        pend_next = pend_keep;
        if (s_tlast)
        begin
            pend_next = PEND_NONE;
            case (pend_keep)
                PEND_ONE:
                begin
                    units[n] = raw_unit(p0_next);
                    n        = 2'(n + 2'd1);
                end
                PEND_TWO:
                begin
                    units[n]           = raw_unit(p0_next);
                    units[2'(n + 2'd1)] = raw_unit(p1_next);
                    n                  = 2'(n + 2'd2);
                end
                default:
                begin
                    n = n;
                end
            endcase
        end
    end

    assign push_valid      = s_tvalid && (n != '0);
    assign push_data.units = units;
    assign push_data.cnt   = n;
    assign push_data.last  = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
    end

endmodule

// ===== rtl/u8dec_queue.sv =====
`timescale 1ns / 1ps
// Short bundle queue between the front end and the output stage.
// Depends on u8dec_pkg.
module u8dec_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  u8dec_pkg::bundle_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output u8dec_pkg::bundle_t pop_data
);
    import u8dec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    bundle_t mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic do_push, do_pop;

    assign push_ready = (fill_reg != FILL_MAX);
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = FILL_W'(fill_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = FILL_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/u8dec_back.sv =====
`timescale 1ns / 1ps
// Output stage: unpacks each bundle into single code units behind an output register.
// Depends on u8dec_pkg.
module u8dec_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  u8dec_pkg::bundle_t pop_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output u8dec_pkg::unit_t   m_tdata,
    output logic               m_tlast
);
    import u8dec_pkg::*;

    cnt_t  idx_reg, idx_next;
    logic  valid_reg, valid_next;
    unit_t data_reg;
    logic  last_reg;
    logic  load;
    logic  final_unit;

    assign load       = pop_valid && (!valid_reg || m_tready);
    assign final_unit = (idx_reg == cnt_t'(pop_data.cnt - 1'b1));
    assign pop_ready  = load && final_unit;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = final_unit ? '0 : cnt_t'(idx_reg + 1'b1);
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pop_data.units[idx_reg];
            last_reg <= pop_data.last && final_unit;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/utf8_to_ucs2_decoder.sv =====
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)       tuser  tlast
// s_*       in   byte_value[7:0]          -      end_of_string
// m_*       out  code_unit[15:0]          -      last_unit
//
// One byte is taken each cycle while the bundle queue has room.
// A code unit passes from the byte that completes it through the bundle queue and the output register.
// A byte that releases two or three units passes them through the output register one at a time.
// The queue holds QUEUE_DEPTH bundles; s_tready falls only when it is full.
// Reset clears the pending sequence, the queue and the output register.
// Top level of the UTF-8 to UCS-2 decoder.
// Depends on u8dec_pkg, u8dec_front, u8dec_queue and u8dec_back.
module utf8_to_ucs2_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_unit[15:0]
    output logic        m_tlast
);
    import u8dec_pkg::*;

    bundle_t push_data, pop_data;
    logic    push_valid, push_ready;
    logic    pop_valid, pop_ready;

    u8dec_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    u8dec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    u8dec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/u8dec_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends only on the top level's ports.
module u8dec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // hold a stalled output item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // a full queue always has an item in the output register
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no output item pending");

    // an accepted end of string is always followed by an output item
    a_eos_yields: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> ##2 m_tvalid)
        else $error("no output item after end of string");

endmodule

bind utf8_to_ucs2_decoder u8dec_checker u_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for utf8_to_ucs2_decoder: drives byte strings on the s_* stream and checks every
// code unit on m_* against an in-bench decoder model. Depends on u8dec_pkg and the decoder RTL.
module tb;
    import u8dec_pkg::*;

    typedef struct {
        unit_t unit;
        logic  last;
    } unit_rec_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    unit_rec_t expected_units [$];
    unit_rec_t want;
    byte_t     held_bytes [2];
    pend_t     held_count;
    int        err_count;
    bit        gap_en;
    bit        stall_en;
    bit        hold_req;

    utf8_to_ucs2_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

    // expected code units for one accepted byte
    function automatic void decode_byte(input byte_t b, input logic eos);
        byte_t     seq [3];
        unit_rec_t outs [$];
        unit_rec_t rec;
        int        n;
        int        i;
        int        k;
        int        need;
        int        avail;
        int        left;
        logic      broken;
        logic      stop;
        n    = 0;
        i    = 0;
        stop = 1'b0;
        for (k = 0; k < int'(held_count); k++)
        begin
            seq[n] = held_bytes[k];
            n++;
        end
        seq[n] = b;
        n++;
        rec.last = 1'b0;
        while (i < n && !stop)
        begin
            if (seq[i][7] == 1'b0 || seq[i][7:6] == 2'b10)
            begin
                rec.unit = {8'h00, seq[i]};
                outs.push_back(rec);
                i++;
            end
            else
            begin
                need   = (seq[i][7:5] == 3'b111) ? 3 : 2;
                avail  = n - i;
                broken = 1'b0;
                for (k = 1; k < need && k < avail; k++)
                    if (seq[i+k][7:6] != 2'b10)
                        broken = 1'b1;
                if (broken)
                begin
                    rec.unit = {8'h00, seq[i]};
                    outs.push_back(rec);
                    i++;
                end
                else if (avail < need)
                    stop = 1'b1;
                else
                begin
                    rec.unit = (need == 3) ? {seq[i][3:0], seq[i+1][5:0], seq[i+2][5:0]}
                                           : {5'b00000, seq[i][4:0], seq[i+1][5:0]};
                    outs.push_back(rec);
                    i += need;
                end
            end
        end
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        if (eos)
        begin
            while (i < n)
            begin
                rec.unit = {8'h00, seq[i]};
                outs.push_back(rec);
                i++;
            end
            held_count = PEND_NONE;
            rec        = outs.pop_back();
            rec.last   = 1'b1;
            outs.push_back(rec);
        end
        else
        begin
            left = n - i;
            for (k = 0; k < left; k++)
                held_bytes[k] = seq[i+k];
            held_count = pend_t'(left);
        end
        foreach (outs[k])
            expected_units.push_back(outs[k]);
    endfunction

    task automatic send_item(input byte_t b, input logic eos);
        if (gap_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b, eos);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_units.size() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed characters, the rest noise and cut-off sequences
    task automatic send_random_string(input int max_len, output int sent);
        byte_t s [$];
        int    target;
        int    k;
        target = $urandom_range(1, max_len);
        while (s.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    s.push_back(byte_t'($urandom_range(1, 127)));
                2, 3:
                begin
                    s.push_back(8'hC0 | byte_t'($urandom_range(0, 31)));
                    s.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
                end
                4, 5, 6:
                begin
                    s.push_back(8'hE0 | byte_t'($urandom_range(0, 31)));
                    s.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
                    s.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
                end
                7:
                    s.push_back(byte_t'($urandom_range(1, 255)));
                8:
                begin
                    s.push_back(8'hC0 | byte_t'($urandom_range(0, 63)));
                    if ($urandom_range(0, 1) == 1)
                        s.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
                end
                default:
                    s.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
            endcase
        end
        for (k = 0; k < s.size(); k++)
            send_item(s[k], k == s.size() - 1);
        sent = s.size();
    endtask

    task automatic run_random(input int n_bytes, input int max_len);
        int total;
        int sent;
        total = 0;
        while (total < n_bytes)
        begin
            send_random_string(max_len, sent);
            total += sent;
        end
        wait_drain();
    endtask

    task automatic test_directed();
        send_item(8'h41, 1'b0); send_item(8'h7F, 1'b0); send_item(8'h00, 1'b0);
        send_item(8'hC3, 1'b0); send_item(8'hA9, 1'b0);
        send_item(8'hE2, 1'b0); send_item(8'h82, 1'b0); send_item(8'hAC, 1'b0);
        send_item(8'hFF, 1'b0); send_item(8'hBF, 1'b0); send_item(8'hBF, 1'b0);
        send_item(8'hC0, 1'b0); send_item(8'h80, 1'b0);
        send_item(8'hE2, 1'b0); send_item(8'h41, 1'b0);
        send_item(8'hE2, 1'b0); send_item(8'h82, 1'b0);
        send_item(8'hC3, 1'b0); send_item(8'hA9, 1'b0);
        send_item(8'h80, 1'b0); send_item(8'hBF, 1'b0);
        send_item(8'hE2, 1'b0); send_item(8'h82, 1'b1);
        send_item(8'hC3, 1'b1);
        send_item(8'h41, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_strings();
        gap_en   = 1'b1;
        stall_en = 1'b1;
        run_random(240, 12);
    endtask

    // hold the output long enough that the queue fills and input stalls
    task automatic test_backpressure();
        gap_en   = 1'b0;
        hold_req = 1'b1;
        run_random(40, 8);
        gap_en   = 1'b1;
    endtask

    task automatic test_full_rate();
        gap_en   = 1'b0;
        stall_en = 1'b0;
        run_random(70, 10);
    endtask

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (48) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_units.size() == 0)
            begin
                $display("%0t: unexpected unit, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (m_tdata !== want.unit)
                begin
                    $display("%0t: code_unit expected %h actual %h", $time, want.unit, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_unit expected %b actual %b", $time, want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        err_count     = 0;
        gap_en        = 1'b1;
        stall_en      = 1'b1;
        hold_req      = 1'b0;
        held_count    = PEND_NONE;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_strings();
        test_backpressure();
        test_full_rate();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
